// File: design/cdll_pkg.sv
// Shared types and constants for the circular doubly linked list engine.
package cdll_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 3;

   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_NEXT   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_PREV   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_READ   = 3'd4;
   localparam logic [OP_BITS-1:0] OP_SEARCH = 3'd5;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO  = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_MISS  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 3'd4;

   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      value_type          item_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      value_type              result_value;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic      fwd_we;
      slot_type  fwd_wa;
      slot_type  fwd_wd;
      logic      bwd_we;
      slot_type  bwd_wa;
      slot_type  bwd_wd;
      logic      val_we;
      slot_type  val_wa;
      value_type val_wd;
   } store_wr_type;

   typedef struct packed {
      slot_type fwd_ra;
      slot_type bwd_ra;
      slot_type val_ra;
   } store_rd_type;

   typedef struct packed {
      slot_type  fwd;
      slot_type  bwd;
      value_type val;
   } store_q_type;

endpackage

// File: design/cdll_store.sv
// Link and value memories of the list, one write and one registered read each.
module cdll_store
   import cdll_pkg::*;
(
   input  logic         clock,
   input  store_wr_type wr,
   input  store_rd_type rd,
   output store_q_type  q
);

   slot_type  fwd_link_ff [CAPACITY];
   slot_type  bwd_link_ff [CAPACITY];
   value_type slot_value_ff [CAPACITY];
   store_q_type q_ff;

   always_ff @(posedge clock) begin
      if (wr.fwd_we) begin
         fwd_link_ff[wr.fwd_wa] <= wr.fwd_wd;
      end
      if (wr.bwd_we) begin
         bwd_link_ff[wr.bwd_wa] <= wr.bwd_wd;
      end
      if (wr.val_we) begin
         slot_value_ff[wr.val_wa] <= wr.val_wd;
      end
      q_ff.fwd <= fwd_link_ff[rd.fwd_ra];
      q_ff.bwd <= bwd_link_ff[rd.bwd_ra];
      q_ff.val <= slot_value_ff[rd.val_ra];
   end

   assign q = q_ff;

endmodule

// File: design/circular_doubly_linked_list_engine.sv
// Top level of the circular doubly linked list engine: sequencer, list state and channels.
//
//   Channel   Direction  Handshake               Payload
//   req       in         req_valid / req_stall   req_data  (op, item_value)
//   rsp       out        rsp_valid / rsp_stall   rsp_data  (status, result_value, entry_count)
//
// A response is registered once a transfer has passed S_DISPATCH, S_FETCH and S_FINISH; next
// and previous add S_STEP, remove adds S_REMOVE, an insert into a nonempty list adds S_INS_A
// and S_INS_B, and search adds S_SEARCH, which compares one linked entry per cycle.
// req_stall falls as the response is registered, and the engine then takes the next request.
// A finished response waits while an older one is held under rsp_stall.
// Reset empties the list at once; the memories need no clearing pass.
module circular_doubly_linked_list_engine
   import cdll_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_INS_A    = 4'd2;
   localparam logic [3:0] S_INS_B    = 4'd3;
   localparam logic [3:0] S_REMOVE   = 4'd4;
   localparam logic [3:0] S_STEP     = 4'd5;
   localparam logic [3:0] S_SEARCH   = 4'd6;
   localparam logic [3:0] S_FETCH    = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0]             state_ff, state_in;
   slot_type               cur_ff, cur_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0]    in_use_ff, in_use_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   value_type              value_ff, value_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   hold_ff, hold_in;
   value_type              held_ff, held_in;
   slot_type               link_ff, link_in;
   slot_type               walk_ff, walk_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   store_wr_type wr;
   store_rd_type rd;
   store_q_type  q;

   logic [CAPACITY-1:0] free_slots;
   logic [CAPACITY-1:0] lowest_free;
   slot_type            fresh;

   cdll_store u_store (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .q     (q)
   );

   // The lowest free slot is isolated as a one-hot word and then encoded.
   always_comb begin
      free_slots  = ~in_use_ff;
      lowest_free = free_slots & (~free_slots + {{(CAPACITY-1){1'b0}}, 1'b1});
      fresh       = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (lowest_free[i]) begin
            fresh = fresh | SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      in_use_in    = in_use_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      hold_in      = hold_ff;
      held_in      = held_ff;
      link_in      = link_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr           = '0;
      rd.fwd_ra    = cur_ff;
      rd.bwd_ra    = cur_ff;
      rd.val_ra    = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.op;
               value_in  = req_data.item_value;
               status_in = STATUS_OK;
               hold_in   = 1'b0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FETCH;
            unique case (op_ff) inside
               OP_INSERT: begin
                  if (value_ff == '0) begin
                     status_in = STATUS_ZERO;
                  end else if (count_ff == COUNT_BITS'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else if (count_ff == '0) begin
                     wr.fwd_we         = 1'b1;
                     wr.fwd_wa         = fresh;
                     wr.fwd_wd         = fresh;
                     wr.bwd_we         = 1'b1;
                     wr.bwd_wa         = fresh;
                     wr.bwd_wd         = fresh;
                     wr.val_we         = 1'b1;
                     wr.val_wa         = fresh;
                     wr.val_wd         = value_ff;
                     in_use_in[fresh]  = 1'b1;
                     cur_in            = fresh;
                     count_in          = count_ff + COUNT_BITS'(1);
                  end else begin
                     state_in = S_INS_A;
                  end
               end
               OP_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     state_in = S_REMOVE;
                  end
               end
               OP_NEXT, OP_PREV: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     state_in = S_STEP;
                  end
               end
               OP_READ: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end
               end
               OP_SEARCH: begin
                  if (value_ff == '0) begin
                     status_in = STATUS_ZERO;
                  end else if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     walk_in  = cur_ff;
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         S_INS_A: begin
            link_in   = q.fwd;
            wr.fwd_we = 1'b1;
            wr.fwd_wa = fresh;
            wr.fwd_wd = q.fwd;
            wr.bwd_we = 1'b1;
            wr.bwd_wa = fresh;
            wr.bwd_wd = cur_ff;
            wr.val_we = 1'b1;
            wr.val_wa = fresh;
            wr.val_wd = value_ff;
            state_in  = S_INS_B;
         end
         S_INS_B: begin
            wr.fwd_we        = 1'b1;
            wr.fwd_wa        = cur_ff;
            wr.fwd_wd        = fresh;
            wr.bwd_we        = 1'b1;
            wr.bwd_wa        = link_ff;
            wr.bwd_wd        = fresh;
            in_use_in[fresh] = 1'b1;
            cur_in           = fresh;
            count_in         = count_ff + COUNT_BITS'(1);
            state_in         = S_FETCH;
         end
         S_REMOVE: begin
            wr.fwd_we         = 1'b1;
            wr.fwd_wa         = q.bwd;
            wr.fwd_wd         = q.fwd;
            wr.bwd_we         = 1'b1;
            wr.bwd_wa         = q.fwd;
            wr.bwd_wd         = q.bwd;
            in_use_in[cur_ff] = 1'b0;
            count_in          = count_ff - COUNT_BITS'(1);
            cur_in            = (count_ff == COUNT_BITS'(1)) ? '0 : q.bwd;
            hold_in           = 1'b1;
            held_in           = q.val;
            state_in          = S_FETCH;
         end
         S_STEP: begin
            cur_in   = (op_ff == OP_NEXT) ? q.fwd : q.bwd;
            state_in = S_FETCH;
         end
         S_SEARCH: begin
            rd.fwd_ra = q.fwd;
            rd.val_ra = q.fwd;
            if (q.val == value_ff) begin
               cur_in   = walk_ff;
               state_in = S_FETCH;
            end else if (q.fwd == cur_ff) begin
               status_in = STATUS_MISS;
               state_in  = S_FETCH;
            end else begin
               walk_in = q.fwd;
            end
         end
         S_FETCH: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.entry_count = count_ff;
               if (hold_ff) begin
                  rsp_in.result_value = held_ff;
               end else if (count_ff == '0) begin
                  rsp_in.result_value = '0;
               end else begin
                  rsp_in.result_value = q.val;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         count_ff     <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      hold_ff   <= hold_in;
      held_ff   <= held_in;
      link_ff   <= link_in;
      walk_ff   <= walk_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_matches_slots: assert property (@(posedge clock) disable iff (reset)
      $countones(in_use_ff) == int'(count_ff))
      else $error("Entry count differs from the number of slots in use.");

   a_empty_current_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (cur_ff == '0))
      else $error("Current slot is not zero while the list is empty.");

   a_current_in_use: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> in_use_ff[cur_ff])
      else $error("Current slot is not in use while the list holds entries.");

   a_empty_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_EMPTY)
         |-> (rsp_data.result_value == '0 && rsp_data.entry_count == '0))
      else $error("Empty-list response carries a value or a nonzero count.");

   a_response_after_finish: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == S_FINISH))
      else $error("Response raised outside the finish step.");
`endif

endmodule

// File: dv/circular_doubly_linked_list_engine_tb.sv
// Self-checking testbench for the circular doubly linked list engine.
module circular_doubly_linked_list_engine_tb
   import cdll_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_BITS-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_BITS-1:0] OP_UNUSED_7 = 3'd7;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int PHASE_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 40;

   class ring_scoreboard;
      slot_type              fwd [CAPACITY];
      slot_type              bwd [CAPACITY];
      value_type             held [CAPACITY];
      logic [CAPACITY-1:0]   in_use;
      slot_type              cur;
      logic [COUNT_BITS-1:0] live;
      rsp_type               due_responses[$];
      int                    failures;

      function new();
         in_use   = '0;
         cur      = '0;
         live     = '0;
         failures = 0;
      endfunction

      function rsp_type apply_list_op(req_type item);
         rsp_type   ans;
         slot_type  fresh;
         slot_type  prv;
         slot_type  nxt;
         slot_type  walk;
         value_type removed;
         logic      took_value;
         logic      hit;
         logic      wrapped;
         ans        = '0;
         ans.status = STATUS_OK;
         took_value = 1'b0;
         removed    = '0;
         case (item.op)
            OP_INSERT: begin
               if (item.item_value == '0) begin
                  ans.status = STATUS_ZERO;
               end else if (live == CAPACITY) begin
                  ans.status = STATUS_FULL;
               end else begin
                  fresh = '0;
                  for (int s = CAPACITY - 1; s >= 0; s--) begin
                     if (!in_use[s]) fresh = slot_type'(s);
                  end
                  in_use[fresh] = 1'b1;
                  held[fresh]   = item.item_value;
                  if (live == 0) begin
                     fwd[fresh] = fresh;
                     bwd[fresh] = fresh;
                  end else begin
                     nxt        = fwd[cur];
                     bwd[fresh] = cur;
                     fwd[fresh] = nxt;
                     fwd[cur]   = fresh;
                     bwd[nxt]   = fresh;
                  end
                  cur  = fresh;
                  live = live + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (live == 0) begin
                  ans.status = STATUS_EMPTY;
               end else begin
                  prv         = bwd[cur];
                  nxt         = fwd[cur];
                  removed     = held[cur];
                  fwd[prv]    = nxt;
                  bwd[nxt]    = prv;
                  in_use[cur] = 1'b0;
                  live        = live - 1'b1;
                  cur         = (live == 0) ? slot_type'(0) : prv;
                  took_value  = 1'b1;
               end
            end
            OP_NEXT, OP_PREV: begin
               if (live == 0) ans.status = STATUS_EMPTY;
               else cur = (item.op == OP_NEXT) ? fwd[cur] : bwd[cur];
            end
            OP_READ: begin
               if (live == 0) ans.status = STATUS_EMPTY;
            end
            OP_SEARCH: begin
               if (item.item_value == '0) begin
                  ans.status = STATUS_ZERO;
               end else if (live == 0) begin
                  ans.status = STATUS_EMPTY;
               end else begin
                  walk    = cur;
                  hit     = 1'b0;
                  wrapped = 1'b0;
                  for (int n = 0; n < CAPACITY && !hit && !wrapped; n++) begin
                     if (held[walk] == item.item_value) begin
                        hit = 1'b1;
                     end else begin
                        walk    = fwd[walk];
                        wrapped = (walk == cur);
                     end
                  end
                  if (hit) cur = walk;
                  else ans.status = STATUS_MISS;
               end
            end
            default: ;
         endcase
         ans.result_value = took_value ? removed : ((live == 0) ? '0 : held[cur]);
         ans.entry_count  = live;
         return ans;
      endfunction

      function void note_request(req_type item);
         due_responses.push_back(apply_list_op(item));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            $error("Response arrived with none outstanding: %p", got);
            failures++;
            return;
         end
         want = due_responses.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.result_value !== want.result_value) begin
            $error("result_value: expected %h, actual %h", want.result_value,
                   got.result_value);
            failures++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   got.entry_count);
            failures++;
         end
      endfunction

      function value_type some_stored_value();
         value_type stored[$];
         for (int s = 0; s < CAPACITY; s++) begin
            if (in_use[s]) stored.push_back(held[s]);
         end
         if (stored.size() == 0) return value_type'($urandom);
         return stored[$urandom_range(0, stored.size() - 1)];
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ring_scoreboard scoreboard = new();
   int  burst_left = 0;
   int  stall_left = 0;
   bit  stall_now = 1'b0;
   bit  draining = 1'b0;

   circular_doubly_linked_list_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) scoreboard.note_request(req_data);
         if (rsp_valid && !rsp_stall) scoreboard.check_response(rsp_data);
      end
   end

   always @(negedge clock) begin
      if (draining) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_now = !stall_now;
            if (stall_now) stall_left = $urandom_range(1, 6);
            else if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(20, 60);
            else stall_left = $urandom_range(1, 8);
         end
         stall_left--;
         rsp_stall <= stall_now;
      end
   end

   task automatic send_item(input logic [OP_BITS-1:0] op, input value_type value);
      req_type item;
      int      gap;
      item.op         = op;
      item.item_value = value;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
         burst_left = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return '1;
            1: return value_type'(1);
            2: return {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
            default: return {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
         endcase
      end
      if (r < 50) return value_type'($urandom_range(1, 12));
      return value_type'($urandom);
   endfunction

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int insert_cut;
      int remove_cut;
      int r;
      logic [OP_BITS-1:0] op;
      value_type value;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(OP_READ, value_type'($urandom));
      send_item(OP_REMOVE, value_type'($urandom));
      send_item(OP_NEXT, value_type'($urandom));
      send_item(OP_PREV, value_type'($urandom));
      send_item(OP_SEARCH, value_type'(5));
      send_item(OP_SEARCH, '0);
      send_item(OP_INSERT, '0);
      send_item(OP_UNUSED_6, value_type'($urandom));
      send_item(OP_UNUSED_7, value_type'($urandom));
      send_item(OP_INSERT, '1);
      send_item(OP_INSERT, value_type'(1));
      send_item(OP_INSERT, {1'b1, {(VALUE_WIDTH - 1){1'b0}}});
      send_item(OP_UNUSED_7, '1);
      send_item(OP_NEXT, '0);
      send_item(OP_PREV, '0);
      send_item(OP_PREV, '0);
      send_item(OP_SEARCH, '1);
      send_item(OP_SEARCH, {1'b0, {(VALUE_WIDTH - 2){1'b1}}, 1'b0});
      send_item(OP_SEARCH, '0);
      send_item(OP_READ, '0);
      send_item(OP_REMOVE, '0);
      send_item(OP_REMOVE, '1);
      send_item(OP_REMOVE, '0);
      send_item(OP_READ, '1);

      // Fill-biased, drain-biased and balanced phases keep the ring moving between empty
      // and full.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            case ($urandom_range(0, 2))
               0: begin insert_cut = 60; remove_cut = 8; end
               1: begin insert_cut = 20; remove_cut = 40; end
               default: begin insert_cut = 30; remove_cut = 20; end
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < insert_cut) begin
            op = OP_INSERT;
         end else if (r < insert_cut + remove_cut) begin
            op = OP_REMOVE;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 22) op = OP_NEXT;
            else if (r < 44) op = OP_PREV;
            else if (r < 59) op = OP_READ;
            else if (r < 96) op = OP_SEARCH;
            else op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
         end
         if (op == OP_SEARCH && $urandom_range(0, 1)) value = scoreboard.some_stored_value();
         else value = pick_value();
         send_item(op, value);
      end
      req_valid <= 1'b0;
      draining = 1'b1;

      while (scoreboard.due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (scoreboard.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: circular_doubly_linked_list_engine.f
design/cdll_pkg.sv
design/cdll_store.sv
design/circular_doubly_linked_list_engine.sv
dv/circular_doubly_linked_list_engine_tb.sv
